@@ hdl/pxfr_pkg.sv @@
// Shared constants and controller/datapath handshake types for the frame receiver.
package pxfr_pkg;

  localparam int unsigned BufBytes = 64;
  localparam int unsigned PosW     = $clog2(BufBytes);
  localparam int unsigned HdrBytes = 3;

  localparam logic [7:0] HdrFirst  = 8'h64;  // 'd'
  localparam logic [7:0] HdrSecond = 8'h78;  // 'x'
  localparam logic [7:0] MaxLenExc = 8'(BufBytes - HdrBytes);

  localparam logic ReqData   = 1'b0;
  localparam logic ReqStatus = 1'b1;

  localparam logic KindFrame  = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRead = 3'b010,
    StShow = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic take;  // input beat accepted this cycle
    logic show;  // load next replay byte into the output register
  } cmd_t;

  typedef struct packed {
    logic good_end;  // current data beat closes a frame with zero checksum
    logic out_free;  // output register can be loaded this cycle
    logic idx_last;  // replay index points at the final frame byte
  } sts_t;

endpackage

@@ hdl/pxfr_datapath.sv @@
// Datapath: header window, checksum, frame store, replay index and output register.
module pxfr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_type_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                out_ready_i,
  input  pxfr_pkg::cmd_t      cmd_i,
  output pxfr_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  output logic                out_kind_o,
  output logic [7:0]          out_byte_o,
  output logic                ack_ok_o,
  output logic                frame_last_o
);

  logic                      in_payload_q, in_payload_d;
  logic [pxfr_pkg::PosW-1:0] wpos_q, wpos_d;
  logic [pxfr_pkg::PosW-1:0] left_q, left_d;
  logic [7:0]                xor_q, xor_d;
  logic                      ack_q, ack_d;
  logic [pxfr_pkg::PosW-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;

  logic [7:0] hdr_q [pxfr_pkg::HdrBytes];
  logic [7:0] hdr_d [pxfr_pkg::HdrBytes];
  logic [7:0] mem_q [pxfr_pkg::BufBytes];
  logic [7:0] rdata_q;

  logic       out_kind_q, out_ack_q, out_last_q;
  logic [7:0] out_byte_q;
  logic [7:0] replay_byte;

  logic take_data, take_status, mem_we, load_out, hdr_good;
  logic [7:0] xor_next;

  assign take_data   = cmd_i.take && (req_type_i == pxfr_pkg::ReqData);
  assign take_status = cmd_i.take && (req_type_i == pxfr_pkg::ReqStatus);
  assign xor_next    = xor_q ^ rx_byte_i;
  assign mem_we      = take_data && in_payload_q;
  assign load_out    = take_status || cmd_i.show;

  // header check on the third window byte (rx_byte_i is the length)
  assign hdr_good = (hdr_q[0] == pxfr_pkg::HdrFirst) && (hdr_q[1] == pxfr_pkg::HdrSecond) &&
                    (rx_byte_i != 8'd0) && (rx_byte_i < pxfr_pkg::MaxLenExc);

  assign sts_o.good_end = (req_type_i == pxfr_pkg::ReqData) && in_payload_q &&
                          (left_q == pxfr_pkg::PosW'(1)) && (xor_next == 8'd0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.idx_last = (idx_q == wpos_q - pxfr_pkg::PosW'(1));

  always_comb begin
    in_payload_d = in_payload_q;
    wpos_d       = wpos_q;
    left_d       = left_q;
    xor_d        = xor_q;
    ack_d        = ack_q;
    hdr_d        = hdr_q;
    if (take_status) begin
      ack_d = 1'b0;
    end else if (take_data && !in_payload_q) begin
      for (int k = 0; k < pxfr_pkg::HdrBytes; k++) begin
        if (wpos_q == pxfr_pkg::PosW'(k)) begin
          hdr_d[k] = rx_byte_i;
        end
      end
      wpos_d = wpos_q + pxfr_pkg::PosW'(1);
      if (wpos_q == pxfr_pkg::PosW'(pxfr_pkg::HdrBytes - 1)) begin
        if (hdr_good) begin
          left_d       = rx_byte_i[pxfr_pkg::PosW-1:0];
          xor_d        = rx_byte_i;
          in_payload_d = 1'b1;
        end else begin
          // slide the window by one byte
          hdr_d[0] = hdr_q[1];
          hdr_d[1] = rx_byte_i;
          wpos_d   = pxfr_pkg::PosW'(pxfr_pkg::HdrBytes - 1);
        end
      end
    end else if (take_data) begin
      xor_d  = xor_next;
      wpos_d = wpos_q + pxfr_pkg::PosW'(1);
      left_d = left_q - pxfr_pkg::PosW'(1);
      if (left_q == pxfr_pkg::PosW'(1)) begin
        in_payload_d = 1'b0;
        ack_d        = (xor_next == 8'd0);
        // good frame keeps its byte count for the replay
        if (xor_next != 8'd0) begin
          wpos_d = '0;
        end
      end
    end else if (cmd_i.show && sts_o.idx_last) begin
      wpos_d = '0;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.take) begin
      idx_d = '0;
    end else if (cmd_i.show) begin
      idx_d = idx_q + pxfr_pkg::PosW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    priority if (idx_q == pxfr_pkg::PosW'(0)) begin
      replay_byte = hdr_q[0];
    end else if (idx_q == pxfr_pkg::PosW'(1)) begin
      replay_byte = hdr_q[1];
    end else if (idx_q == pxfr_pkg::PosW'(2)) begin
      replay_byte = hdr_q[2];
    end else begin
      replay_byte = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      wpos_q       <= '0;
      left_q       <= '0;
      xor_q        <= '0;
      ack_q        <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      in_payload_q <= in_payload_d;
      wpos_q       <= wpos_d;
      left_q       <= left_d;
      xor_q        <= xor_d;
      ack_q        <= ack_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wpos_q] <= rx_byte_i;
    end
    rdata_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (take_status) begin
      out_kind_q <= pxfr_pkg::KindStatus;
      out_byte_q <= 8'd0;
      out_ack_q  <= ack_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.show) begin
      out_kind_q <= pxfr_pkg::KindFrame;
      out_byte_q <= replay_byte;
      out_ack_q  <= 1'b0;
      out_last_q <= sts_o.idx_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_byte_o   = out_byte_q;
  assign ack_ok_o     = out_ack_q;
  assign frame_last_o = out_last_q;

`ifndef ASSERT_OFF
  a_payload_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (wpos_q >= pxfr_pkg::PosW'(pxfr_pkg::HdrBytes) && left_q != '0))
    else $error("payload collection with bad position or count");

  a_show_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.show |-> (idx_q < wpos_q && !in_payload_q))
    else $error("replay index beyond frame");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");
`endif

endmodule

@@ hdl/pxfr_ctrl.sv @@
// Controller: input handshake and frame replay sequencing.
module pxfr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  output logic           in_ready_o,
  input  pxfr_pkg::sts_t sts_i,
  output pxfr_pkg::cmd_t cmd_o
);

  pxfr_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    in_ready_o = (state_q == pxfr_pkg::StIdle) &&
                 ((req_type_i == pxfr_pkg::ReqData) || sts_i.out_free);
    cmd_o.take = in_valid_i && in_ready_o;
    cmd_o.show = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      pxfr_pkg::StIdle: begin
        if (cmd_o.take && sts_i.good_end) begin
          state_d = pxfr_pkg::StRead;
        end
      end
      pxfr_pkg::StRead: begin
        state_d = pxfr_pkg::StShow;
      end
      pxfr_pkg::StShow: begin
        if (sts_i.out_free) begin
          cmd_o.show = 1'b1;
          state_d    = sts_i.idx_last ? pxfr_pkg::StIdle : pxfr_pkg::StRead;
        end
      end
      default: begin
        state_d = pxfr_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pxfr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/preamble_xor_frame_receiver.sv @@
// Top level of the preamble/length/XOR frame receiver.
// A status reply is on the output in the cycle after its beat is taken.
// After its last payload beat a good frame is replayed, header included, and no
// input is taken; each byte is a store read, then an output register load.
// Throughput: one input beat per cycle outside replay; status waits on out_free.
// Reset: async active low clears control state; the frame store is not cleared.
module preamble_xor_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       ack_ok_o,
  output logic       frame_last_o
);

  // Controller owns the input handshake and the replay sequence; the
  // datapath owns the header window, checksum, store and output beat.
  pxfr_pkg::cmd_t cmd;
  pxfr_pkg::sts_t sts;

  pxfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Status reads need the output register; data beats never wait on it.
  pxfr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .ack_ok_o     (ack_ok_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ test/pxfr_frame_checker.sv @@
// Scoreboard for the frame receiver: watches both channels, predicts replies, compares.
module pxfr_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       out_kind_i,
  input  logic [7:0] out_byte_i,
  input  logic       ack_ok_i,
  input  logic       frame_last_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       ack;
    logic       last;
  } reply_t;

  // predictor state
  logic                      in_frame;
  logic [pxfr_pkg::PosW-1:0] wr_pos;
  logic [pxfr_pkg::PosW-1:0] left_cnt;
  logic [7:0]                xsum;
  logic                      ack_flag;
  logic [7:0]                frame_mem [pxfr_pkg::BufBytes];
  reply_t                    reply_q [$];

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors_o++;
  endtask

  function automatic reply_t make_reply(logic kind, logic [7:0] data, logic ack, logic last);
    reply_t r;
    r.kind = kind;
    r.data = data;
    r.ack  = ack;
    r.last = last;
    return r;
  endfunction

  task automatic take_beat(input logic req, input logic [7:0] b);
    logic [7:0] len;
    if (req == pxfr_pkg::ReqStatus) begin
      reply_q.push_back(make_reply(pxfr_pkg::KindStatus, 8'h00, ack_flag, 1'b1));
      ack_flag = 1'b0;
    end else if (!in_frame) begin
      // header hunt: three-byte window
      frame_mem[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
      if (wr_pos >= pxfr_pkg::HdrBytes) begin
        len = frame_mem[2];
        if (frame_mem[0] == pxfr_pkg::HdrFirst && frame_mem[1] == pxfr_pkg::HdrSecond &&
            len != 8'd0 && len < pxfr_pkg::MaxLenExc) begin
          left_cnt = len[pxfr_pkg::PosW-1:0];
          xsum     = len;
          in_frame = 1'b1;
        end else begin
          frame_mem[0] = frame_mem[1];
          frame_mem[1] = frame_mem[2];
          wr_pos = pxfr_pkg::PosW'(2);
        end
      end
    end else begin
      xsum = xsum ^ b;
      frame_mem[wr_pos] = b;
      wr_pos   = wr_pos + 1'b1;
      left_cnt = left_cnt - 1'b1;
      if (left_cnt == 0) begin
        if (xsum == 8'd0) begin
          ack_flag = 1'b1;
          for (int i = 0; i < wr_pos; i++) begin
            reply_q.push_back(make_reply(pxfr_pkg::KindFrame, frame_mem[i], 1'b0,
                                         (i + 1) == wr_pos));
          end
        end else begin
          ack_flag = 1'b0;
        end
        wr_pos   = '0;
        in_frame = 1'b0;
      end
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      flag_error($sformatf("unexpected beat kind=%0b byte=%02h ack=%0b last=%0b",
                           out_kind_i, out_byte_i, ack_ok_i, frame_last_i));
    end else begin
      want = reply_q.pop_front();
      if (out_kind_i !== want.kind)
        flag_error($sformatf("out_kind got %0b want %0b", out_kind_i, want.kind));
      if (out_byte_i !== want.data)
        flag_error($sformatf("out_byte got %02h want %02h", out_byte_i, want.data));
      if (ack_ok_i !== want.ack)
        flag_error($sformatf("ack_ok got %0b want %0b", ack_ok_i, want.ack));
      if (frame_last_i !== want.last)
        flag_error($sformatf("frame_last got %0b want %0b", frame_last_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame  = 1'b0;
      wr_pos    = '0;
      left_cnt  = '0;
      xsum      = 8'd0;
      ack_flag  = 1'b0;
      for (int i = 0; i < pxfr_pkg::BufBytes; i++) frame_mem[i] = 8'd0;
      reply_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      // a reply never leaves in the cycle its beat enters, so order is free
      if (out_valid_i && out_ready_i) check_reply();
      if (in_valid_i && in_ready_i) take_beat(req_type_i, rx_byte_i);
      pending_o = reply_q.size();
    end
  end

endmodule

@@ test/preamble_xor_frame_receiver_tb.sv @@
// Stimulus, clocking and verdict for the preamble/XOR frame receiver.
module preamble_xor_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 4000;  // cycles with no beat on either side
  localparam int TailCycles = 40;
  localparam int RandBeats  = 210;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic       req_type   = pxfr_pkg::ReqData;
  logic [7:0] rx_byte    = 8'h00;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       ack_ok;
  logic       frame_last;

  int errors;
  int pending;
  int beats_sent = 0;
  bit no_gap     = 1'b0;  // sender burst mode: back-to-back beats

  preamble_xor_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_kind_o  (out_kind),
    .out_byte_o  (out_byte),
    .ack_ok_o    (ack_ok),
    .frame_last_o(frame_last)
  );

  pxfr_frame_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .req_type_i  (req_type),
    .rx_byte_i   (rx_byte),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_kind_i  (out_kind),
    .out_byte_i  (out_byte),
    .ack_ok_i    (ack_ok),
    .frame_last_i(frame_last),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // One input beat. Valid rises at a clock edge and holds until the beat is
  // taken; the idle gap comes after the beat so a zero gap keeps valid high
  // without a second assignment in the same step.
  task automatic send_beat(input logic req, input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    beats_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender off until every predicted reply has left the block.
  // Checker-owned counters are read on the falling edge to stay race free.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Well-formed frame: 'd', 'x', length, payload. The last payload byte
  // closes the XOR to zero for a good frame, or to a nonzero value for a bad
  // one. Status reads are sprinkled between payload beats.
  task automatic send_frame(input int unsigned len, input bit good);
    logic [7:0] sum;
    logic [7:0] pay;
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
    send_beat(pxfr_pkg::ReqData, 8'(len));
    sum = 8'(len);
    for (int unsigned i = 1; i <= len; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(pxfr_pkg::ReqStatus, 8'($urandom));
      if (i < len) pay = 8'($urandom);
      else pay = good ? sum : (sum ^ 8'($urandom_range(1, 255)));
      sum = sum ^ pay;
      send_beat(pxfr_pkg::ReqData, pay);
    end
  endtask

  // Receiver side: runs of ready, usually short, sometimes long stretches
  // with no stall at all, broken by gaps of random length.
  initial begin
    int run;
    int gap;
    wait (rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Watchdog: ends the run when the channels sit still too long.
  initial begin
    int idle;
    idle = 0;
    wait (rst_ni);
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int pick;
    int unsigned len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    send_beat(pxfr_pkg::ReqStatus, 8'hFF);          // flag is clear after reset
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);   // shortest good frame, length 1
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
    send_beat(pxfr_pkg::ReqData, 8'd1);
    send_beat(pxfr_pkg::ReqData, 8'd1);
    wait_drained();                                 // sender holds until replay is out
    send_beat(pxfr_pkg::ReqStatus, 8'h00);          // reads a set flag
    send_beat(pxfr_pkg::ReqStatus, 8'h00);          // already read, so clear
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);   // zero length: window slides on
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
    send_beat(pxfr_pkg::ReqData, 8'd0);
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);   // length at the buffer bound
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::MaxLenExc);
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);   // good frame, status read inside
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
    send_beat(pxfr_pkg::ReqData, 8'd2);
    send_beat(pxfr_pkg::ReqStatus, 8'h5A);
    send_beat(pxfr_pkg::ReqData, 8'hFF);
    send_beat(pxfr_pkg::ReqData, 8'hFD);
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);   // bad checksum clears the flag
    send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
    send_beat(pxfr_pkg::ReqData, 8'd1);
    send_beat(pxfr_pkg::ReqData, 8'h00);
    send_beat(pxfr_pkg::ReqStatus, 8'hA5);

    // ---- random part ----
    send_frame(pxfr_pkg::MaxLenExc - 1, 1'b1);      // longest legal frame, once
    wait_drained();
    while (beats_sent < RandBeats) begin
      no_gap = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // mostly short frames, a few long ones
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(1, pxfr_pkg::MaxLenExc - 1)
                                            : $urandom_range(1, 8);
        send_frame(len, $urandom_range(0, 3) != 0);
      end else if (pick < 80) begin
        send_beat(pxfr_pkg::ReqStatus, 8'($urandom));
      end else if (pick < 90) begin
        // header with an illegal length: zero or at/above the bound
        send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);
        send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrSecond);
        send_beat(pxfr_pkg::ReqData,
                  ($urandom_range(0, 3) == 0) ? 8'd0
                                              : 8'($urandom_range(pxfr_pkg::MaxLenExc, 255)));
      end else if (pick < 95) begin
        // broken preamble
        send_beat(pxfr_pkg::ReqData, pxfr_pkg::HdrFirst);
        send_beat(pxfr_pkg::ReqData, 8'($urandom));
      end else begin
        send_beat(pxfr_pkg::ReqData, 8'($urandom));
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    no_gap = 1'b0;

    // ---- wind down ----
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
